### hdl/base62_codec_assert.svh
// Assertion macros shared by the base-62 codec checker.
// Pulled in by bare file name; needs no other file.
`ifndef BASE62_CODEC_ASSERT_SVH
`define BASE62_CODEC_ASSERT_SVH

// Same-cycle implication, reset-gated.
`define B62_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-gated.
`define B62_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/b62_pkg.sv
// Types, codes, microcode program and character tables for the base-62 codec.
// No dependencies.
package b62_pkg;

    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;
    localparam logic KIND_DIGIT = 1'b0;
    localparam logic KIND_VALUE = 1'b1;
    localparam int   RADIX      = 62;
    localparam int   DIGIT_W    = 6;
    localparam int   CHUNK_BITS = 8;

    typedef struct packed {
        logic        action;
        logic [63:0] value;
        logic [7:0]  char_in;
        logic        end_of_string;
    } b62_in_t;

    typedef struct packed {
        logic        kind;
        logic [6:0]  digit_char;
        logic [63:0] decoded;
        logic        last;
    } b62_out_t;

    typedef enum logic [2:0] {
        OP_NOP, OP_LOAD, OP_DIV, OP_STORE, OP_EMIT, OP_MAC, OP_DOUT
    } op_t;

    typedef enum logic [1:0] {
        H_NONE, H_IN, H_OUT, H_DIV
    } hold_t;

    typedef enum logic [2:0] {
        J_NEVER, J_ALWAYS, J_DECODE, J_MORE, J_NOT_EOS, J_COUNT_LEFT
    } jcond_t;

    typedef logic [2:0] upc_t;

    localparam upc_t STEP_IDLE  = 3'd0;
    localparam upc_t STEP_DIV   = 3'd1;
    localparam upc_t STEP_STORE = 3'd2;
    localparam upc_t STEP_EMIT  = 3'd3;
    localparam upc_t STEP_BACK  = 3'd4;
    localparam upc_t STEP_MAC   = 3'd5;
    localparam upc_t STEP_DOUT  = 3'd6;

    typedef struct packed {
        op_t    op;
        hold_t  hold;
        jcond_t jcond;
        upc_t   target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic exec;
    } b62_ctrl_t;

    typedef struct packed {
        logic eos;
        logic chunk_last;
        logic more;
        logic count_left;
        logic out_free;
    } b62_status_t;

    // Control store. Fall-through goes to the next step.
    function automatic uword_t b62_ucode(upc_t addr);
        uword_t w;
        unique case (addr)
            STEP_IDLE:  w = '{OP_LOAD,  H_IN,   J_DECODE,     STEP_MAC};
            STEP_DIV:   w = '{OP_DIV,   H_DIV,  J_NEVER,      STEP_IDLE};
            STEP_STORE: w = '{OP_STORE, H_NONE, J_MORE,       STEP_DIV};
            STEP_EMIT:  w = '{OP_EMIT,  H_OUT,  J_COUNT_LEFT, STEP_EMIT};
            STEP_BACK:  w = '{OP_NOP,   H_NONE, J_ALWAYS,     STEP_IDLE};
            STEP_MAC:   w = '{OP_MAC,   H_NONE, J_NOT_EOS,    STEP_IDLE};
            STEP_DOUT:  w = '{OP_DOUT,  H_OUT,  J_ALWAYS,     STEP_IDLE};
            default:    w = '{OP_NOP,   H_NONE, J_ALWAYS,     STEP_IDLE};
        endcase
        return w;
    endfunction

    // Anything outside the alphabet maps to digit 0.
    function automatic logic [DIGIT_W-1:0] char_to_digit(logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'd48 && c <= 8'd57) begin
            d = c - 8'd48;
        end else if (c >= 8'd65 && c <= 8'd90) begin
            d = c - 8'd55;
        end else if (c >= 8'd97 && c <= 8'd122) begin
            d = c - 8'd61;
        end
        return d[DIGIT_W-1:0];
    endfunction

    function automatic logic [6:0] digit_to_char(logic [DIGIT_W-1:0] d);
        logic [6:0] dx;
        logic [6:0] ch;
        dx = {1'b0, d};
        if (dx < 7'd10) begin
            ch = 7'd48 + dx;
        end else if (dx < 7'd36) begin
            ch = 7'd55 + dx;
        end else begin
            ch = 7'd61 + dx;
        end
        return ch;
    endfunction

endpackage

### hdl/b62_div_step.sv
// One long-division step by 62: eight quotient bits per call.
// Depends on b62_pkg.
module b62_div_step (
    input  logic [b62_pkg::DIGIT_W-1:0]    rem_in,
    input  logic [b62_pkg::CHUNK_BITS-1:0] chunk,
    output logic [b62_pkg::CHUNK_BITS-1:0] quo,
    output logic [b62_pkg::DIGIT_W-1:0]    rem_out
);
    import b62_pkg::*;

    always_comb begin
        logic [DIGIT_W:0] r;
        r = {1'b0, rem_in};
        quo = '0;
        for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
            // remainder stays below 62, so the shifted value fits in 7 bits
            r = {r[DIGIT_W-1:0], chunk[i]};
            if (r >= (DIGIT_W+1)'(RADIX)) begin
                r = r - (DIGIT_W+1)'(RADIX);
                quo[i] = 1'b1;
            end
        end
        rem_out = r[DIGIT_W-1:0];
    end

endmodule

### hdl/b62_datapath.sv
// Datapath of the base-62 codec: dividend, digit buffer, decode accumulator,
// output register. Driven by control words; depends on b62_pkg and b62_div_step.
module b62_datapath #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  b62_pkg::b62_in_t     s_data,
    input  b62_pkg::b62_ctrl_t   ctrl,
    output b62_pkg::b62_status_t status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output b62_pkg::b62_out_t    m_data
);
    import b62_pkg::*;

    localparam int CHUNKS  = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PAD_W   = CHUNKS * CHUNK_BITS;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W   = $clog2(MAX_DIGITS);

    logic [PAD_W-1:0]       val_reg, val_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [CHUNK_W-1:0]     chunk_reg, chunk_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [7:0]             char_reg, char_next;
    logic                   eos_reg, eos_next;
    logic [DIGIT_W-1:0]     dbuf_reg [MAX_DIGITS];
    logic                   m_valid_reg, m_valid_next;
    b62_out_t               m_data_reg, m_data_next;

    logic [CHUNK_BITS-1:0]  quo;
    logic [DIGIT_W-1:0]     rem_step;
    logic [IDX_W-1:0]       rd_idx;
    logic                   chunk_last;
    logic                   out_free;

    b62_div_step u_div (
        .rem_in  (rem_reg),
        .chunk   (val_reg[PAD_W-1 -: CHUNK_BITS]),
        .quo     (quo),
        .rem_out (rem_step)
    );

    assign chunk_last = (chunk_reg == CHUNK_W'(CHUNKS - 1));
    assign out_free   = !m_valid_reg || m_ready;
    assign rd_idx     = IDX_W'(count_reg - CNT_W'(1));

    assign status = '{
        eos:        eos_reg,
        chunk_last: chunk_last,
        more:       (val_reg != '0) && (count_reg != CNT_W'(MAX_DIGITS - 1)),
        count_left: (count_reg != CNT_W'(1)),
        out_free:   out_free
    };

    always_comb begin
        val_next     = val_reg;
        rem_next     = rem_reg;
        chunk_next   = chunk_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        char_next    = char_reg;
        eos_next     = eos_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (ctrl.exec) begin
            unique case (ctrl.op)
                OP_LOAD: begin
                    if (s_data.action == ACT_ENCODE) begin
                        val_next   = PAD_W'(s_data.value[VALUE_WIDTH-1:0]);
                        rem_next   = '0;
                        chunk_next = '0;
                        count_next = '0;
                    end else begin
                        char_next = s_data.char_in;
                        eos_next  = s_data.end_of_string;
                    end
                end
                OP_DIV: begin
                    val_next   = (val_reg << CHUNK_BITS) | PAD_W'(quo);
                    rem_next   = rem_step;
                    chunk_next = chunk_last ? '0 : chunk_reg + CHUNK_W'(1);
                end
                OP_STORE: begin
                    count_next = count_reg + CNT_W'(1);
                    rem_next   = '0;
                end
                OP_EMIT: begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{
                        kind:       KIND_DIGIT,
                        digit_char: digit_to_char(dbuf_reg[rd_idx]),
                        decoded:    64'd0,
                        last:       (count_reg == CNT_W'(1))
                    };
                    count_next = count_reg - CNT_W'(1);
                end
                OP_MAC: begin
                    // acc*62 = acc*64 - acc*2
                    acc_next = (acc_reg << 6) - (acc_reg << 1)
                               + VALUE_WIDTH'(char_to_digit(char_reg));
                end
                OP_DOUT: begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{
                        kind:       KIND_VALUE,
                        digit_char: 7'd0,
                        decoded:    64'(acc_reg),
                        last:       1'b1
                    };
                    acc_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_reg   <= '0;
            count_reg   <= '0;
            acc_reg     <= '0;
            eos_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            chunk_reg   <= chunk_next;
            count_reg   <= count_next;
            acc_reg     <= acc_next;
            eos_reg     <= eos_next;
            m_valid_reg <= m_valid_next;
        end
        val_reg    <= val_next;
        rem_reg    <= rem_next;
        char_reg   <= char_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.exec && ctrl.op == OP_STORE) begin
            dbuf_reg[count_reg[IDX_W-1:0]] <= rem_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hdl/base62_codec.sv
// Base-62 codec (alphabet 0-9, A-Z, a-z). An encode request turns a number into its
// digits, most significant first, at least one, last flagged; a decode request feeds
// one character, and the character flagged end_of_string returns the value (mod
// 2^VALUE_WIDTH) and clears the accumulator. Requests are taken one at a time. An
// encode divides the value by 62 once per digit, with a divide-by-62 unit that
// retires 8 dividend bits per cycle, then sends out the stored digits; a decode
// character is loaded and then accumulated, and the final one also sends out the
// value; both wait on any output stall. A result register holds the last result.
// Depends on b62_pkg, b62_datapath, b62_div_step.
module base62_codec #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 11
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  b62_pkg::b62_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output b62_pkg::b62_out_t m_data
);
    import b62_pkg::*;

    upc_t        upc_reg, upc_next;
    uword_t      uw;
    b62_ctrl_t   ctrl;
    b62_status_t status;
    logic        go;
    logic        take_jump;

    assign uw = b62_ucode(upc_reg);

    always_comb begin
        unique case (uw.hold)
            H_NONE:  go = 1'b1;
            H_IN:    go = s_valid;
            H_OUT:   go = status.out_free;
            H_DIV:   go = status.chunk_last;
            default: go = 1'b1;
        endcase
        unique case (uw.jcond)
            J_NEVER:      take_jump = 1'b0;
            J_ALWAYS:     take_jump = 1'b1;
            J_DECODE:     take_jump = (s_data.action == ACT_DECODE);
            J_MORE:       take_jump = status.more;
            J_NOT_EOS:    take_jump = !status.eos;
            J_COUNT_LEFT: take_jump = status.count_left;
            default:      take_jump = 1'b0;
        endcase
        if (!go) begin
            upc_next = upc_reg;
        end else if (take_jump) begin
            upc_next = uw.target;
        end else begin
            upc_next = upc_reg + upc_t'(1);
        end
    end

    // divide steps run every cycle; the hold only gates leaving the step
    assign ctrl    = '{op: uw.op, exec: go || (uw.hold == H_DIV)};
    assign s_ready = (uw.hold == H_IN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= STEP_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

    b62_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .ctrl    (ctrl),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### hdl/b62_checker.sv
// Port-level checker for the base-62 codec, bound to the top level.
// Depends on b62_pkg and base62_codec_assert.svh.
`include "base62_codec_assert.svh"

module b62_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input b62_pkg::b62_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input b62_pkg::b62_out_t m_data
);
    import b62_pkg::*;

    `B62_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `B62_ASSERT_NOW(a_value_last, aclk, aresetn, m_valid && m_data.kind == KIND_VALUE, m_data.last && m_data.digit_char == 7'd0, "decoded value without last or with stray digit")
    `B62_ASSERT_NOW(a_digit_alpha, aclk, aresetn, m_valid && m_data.kind == KIND_DIGIT, m_data.decoded == 64'd0 && ((m_data.digit_char >= 7'd48 && m_data.digit_char <= 7'd57) || (m_data.digit_char >= 7'd65 && m_data.digit_char <= 7'd90) || (m_data.digit_char >= 7'd97 && m_data.digit_char <= 7'd122)), "digit outside alphabet")
    `B62_ASSERT_NEXT(a_enc_busy, aclk, aresetn, s_valid && s_ready && s_data.action == ACT_ENCODE, !s_ready, "new request taken during encode")

endmodule

bind base62_codec b62_checker u_b62_checker (.*);

### bench/base62_codec_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for base62_codec: encode and decode requests, with a scoreboard
// that predicts each digit and decoded value. Depends on b62_pkg and the codec RTL.
module base62_codec_tb;
    import b62_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 150;   // longer than an 11-digit encode
    localparam logic [7:0] EDGE_CHARS [13] = '{
        8'h00, 8'h2F, 8'h39, 8'h3A, 8'h40, 8'h41, 8'h5A,
        8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B, 8'hFF
    };

    // Predicts codec output and matches it against what comes out.
    class codec_scoreboard;
        localparam int DIGIT_LIMIT = 11;
        b62_out_t    expected_out[$];
        logic [63:0] running_value;
        int          failures;
        int          encodes;
        int          decode_chars;
        int          strings_closed;
        int          results_seen;

        function new();
            running_value = '0;
        endfunction

        static function logic [6:0] glyph(logic [5:0] d);
            if (d < 6'd10) return 7'h30 + 7'(d);
            if (d < 6'd36) return 7'h41 + 7'(d - 6'd10);
            return 7'h61 + 7'(d - 6'd36);
        endfunction

        static function logic [5:0] glyph_value(logic [7:0] c);
            if (c inside {[8'h30:8'h39]}) return 6'(c - 8'h30);
            if (c inside {[8'h41:8'h5A]}) return 6'(c - 8'h41 + 8'd10);
            if (c inside {[8'h61:8'h7A]}) return 6'(c - 8'h61 + 8'd36);
            return 6'd0;   // junk counts as zero
        endfunction

        function int pending();
            return expected_out.size();
        endfunction

        function void queue_result(b62_out_t r);
            expected_out = {expected_out, r};
        endfunction

        function void note_request(b62_in_t req);
            logic [5:0]  digits[$];
            logic [63:0] v;
            b62_out_t    r;
            if (req.action == ACT_ENCODE) begin
                encodes++;
                v = req.value;
                do begin
                    digits.push_front(6'(v % 64'd62));
                    v = v / 64'd62;
                end while (v != 0 && digits.size() < DIGIT_LIMIT);
                foreach (digits[i]) begin
                    r            = '0;
                    r.kind       = KIND_DIGIT;
                    r.digit_char = glyph(digits[i]);
                    r.last       = (i == digits.size() - 1);
                    queue_result(r);
                end
            end else begin
                decode_chars++;
                running_value = running_value * 64'd62 + 64'(glyph_value(req.char_in));
                if (req.end_of_string) begin
                    strings_closed++;
                    r         = '0;
                    r.kind    = KIND_VALUE;
                    r.decoded = running_value;
                    r.last    = 1'b1;
                    queue_result(r);
                    running_value = '0;
                end
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t mismatch on %s: expected %0h actual %0h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(b62_out_t got);
            b62_out_t want;
            if (expected_out.size() == 0) begin
                $display("%0t unexpected result: expected none actual kind %0d char %0h value %0h last %0d",
                         $time, got.kind, got.digit_char, got.decoded, got.last);
                failures++;
                return;
            end
            want = expected_out.pop_front();
            results_seen++;
            compare_field("kind", 64'(want.kind), 64'(got.kind));
            compare_field("digit_char", 64'(want.digit_char), 64'(got.digit_char));
            compare_field("decoded", want.decoded, got.decoded);
            compare_field("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    b62_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    b62_out_t m_data;

    codec_scoreboard board = new();
    int send_idle_pct;
    int recv_idle_pct;
    int sent_total;
    int cycle_count;

    base62_codec u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (recv_idle_pct == 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_request(s_data);
            if (m_valid && m_ready) board.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles, %0d results still due",
                     $time, cycle_count, board.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_request(input b62_in_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_total++;
    endtask

    task automatic send_encode(input logic [63:0] value);
        b62_in_t req;
        req.action        = ACT_ENCODE;
        req.value         = value;
        req.char_in       = 8'($urandom);
        req.end_of_string = 1'($urandom);
        send_request(req);
    endtask

    task automatic send_decode(input logic [7:0] ch, input logic eos);
        b62_in_t req;
        req.action        = ACT_DECODE;
        req.value         = {$urandom, $urandom};
        req.char_in       = ch;
        req.end_of_string = eos;
        send_request(req);
    endtask

    function automatic logic [63:0] random_value();
        if ($urandom_range(9) == 0) return 64'($urandom_range(61));
        return {$urandom, $urandom} >> $urandom_range(63);
    endfunction

    function automatic logic [7:0] random_char();
        if ($urandom_range(99) < 12) return 8'($urandom_range(255));
        return 8'(codec_scoreboard::glyph(6'($urandom_range(61))));
    endfunction

    // Mostly whole strings and encodes; a slice of raw noise on top.
    task automatic random_traffic(input int target);
        int      pick;
        int      len;
        b62_in_t junk;
        while (sent_total < target) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                send_encode(random_value());
            end else if (pick < 90) begin
                len = $urandom_range(1, 13);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(99) < 4) send_encode(random_value());
                    send_decode(random_char(), i == len - 1);
                end
            end else begin
                junk.action        = 1'($urandom);
                junk.value         = {$urandom, $urandom};
                junk.char_in       = 8'($urandom);
                junk.end_of_string = 1'($urandom);
                send_request(junk);
            end
        end
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        // let the scoreboard log the request taken on this edge first
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        send_idle_pct = 29;
        recv_idle_pct = 57;
        sent_total    = 0;
        cycle_count   = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero, one- and two-digit edges, 10 vs 11 digits, full width
        send_encode(64'd0);
        send_encode(64'd1);
        send_encode(64'd61);
        send_encode(64'd62);
        send_encode(64'd839299365868340223);
        send_encode(64'd839299365868340224);
        send_encode(64'hFFFF_FFFF_FFFF_FFFF);
        send_encode(64'h8000_0000_0000_0000);
        send_decode(8'h30, 1'b1);
        // alphabet edges and their junk neighbors; 13 digits also wraps
        for (int i = 0; i < $size(EDGE_CHARS); i++) begin
            send_decode(EDGE_CHARS[i], i == $size(EDGE_CHARS) - 1);
        end
        // encode in the middle of a string must leave the accumulator alone
        send_decode(8'h7A, 1'b0);
        send_encode(64'd5);
        send_decode(8'h7A, 1'b1);

        random_traffic(160);
        pause_until_drained();

        send_idle_pct = 57;
        recv_idle_pct = 29;
        random_traffic(295);
        pause_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(430);
        pause_until_drained();

        $display("Covered %0d requests: %0d encodes, %0d decode characters, %0d strings closed.",
                 sent_total, board.encodes, board.decode_chars, board.strings_closed);
        $display("Checked %0d results under three sender/receiver idle patterns.",
                 board.results_seen);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### base62_codec.f
+incdir+hdl
hdl/b62_pkg.sv
hdl/b62_div_step.sv
hdl/b62_datapath.sv
hdl/base62_codec.sv
hdl/b62_checker.sv
bench/base62_codec_tb.sv
